// File: rtl/rsct_pkg.sv
// Shared types and constants for the random single-cycle successor table.
`timescale 1ns / 1ps

package rsct_pkg;

  // Fixed field widths
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int SEED_W  = 48;
  localparam int DRAW_W  = 31;
  localparam int MUL_W   = 35;

  // Default depth of the slot stores
  localparam int SLOT_DEPTH_DEFAULT = 1024;

  // Register reset values
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;
  localparam logic [SEED_W-1:0]  SEED_RESET        = 48'hCAFE_BEEF_DEAD;

  // Linear congruential generator constants
  localparam logic [MUL_W-1:0]  LCG_MUL = 35'h5_DEEC_E66D;
  localparam logic [SEED_W-1:0] LCG_ADD = 48'hB;

  // Configuration register indexes
  localparam logic CFG_ENTRY_COUNT = 1'b0;
  localparam logic CFG_RNG_SEED    = 1'b1;

  // Command codes
  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_READ     = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_DRAW,
    ST_DRAW_WAIT,
    ST_SWAP_RD_I,
    ST_SWAP_RD_P,
    ST_SWAP_WR_I,
    ST_SWAP_WR_P,
    ST_TAIL,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_READ,
    ST_RESULT
  } top_state_t;

  // Draw unit phases
  typedef enum logic [1:0] {
    DR_IDLE,
    DR_MUL,
    DR_DIV,
    DR_DONE
  } draw_phase_t;

  // Requests from the controller to the draw unit
  typedef struct packed {
    logic load;
    logic start;
  } draw_ctrl_t;

endpackage

// File: rtl/rsct_draw.sv
// Bit-serial generator step and remainder unit: one LCG step, then draw mod divisor.
`timescale 1ns / 1ps

module rsct_draw #(
  parameter int SLOT_DEPTH = rsct_pkg::SLOT_DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rsct_pkg::draw_ctrl_t                   ctrl,
  input  logic [rsct_pkg::SEED_W-1:0]            seed,
  input  logic [$clog2(SLOT_DEPTH+1)-1:0]        divisor,
  output logic                                   done,
  output logic [$clog2(SLOT_DEPTH+1)-1:0]        remainder
);

  localparam int CNT_W = $clog2(SLOT_DEPTH + 1);

  rsct_pkg::draw_phase_t phase, phase_next;

  logic [rsct_pkg::SEED_W-1:0] gen_x;
  logic [rsct_pkg::SEED_W-1:0] acc;
  logic [rsct_pkg::SEED_W-1:0] acc_sum;
  logic [rsct_pkg::SEED_W-1:0] step_out;
  logic [5:0]                  mul_cnt;
  logic [rsct_pkg::DRAW_W-1:0] quot;
  logic [4:0]                  div_cnt;
  logic [CNT_W-1:0]            div_r;
  logic [CNT_W-1:0]            rem;
  logic [CNT_W:0]              rem_sh;
  logic [CNT_W:0]              rem_sub;

  // Multiplier bits are taken most significant first: shift and add.
  assign acc_sum  = {acc[rsct_pkg::SEED_W-2:0], 1'b0}
                  + (rsct_pkg::LCG_MUL[mul_cnt] ? gen_x : '0);
  assign step_out = acc_sum + rsct_pkg::LCG_ADD;

  // Restoring division, one quotient bit a cycle.
  assign rem_sh  = {rem, quot[rsct_pkg::DRAW_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};

  // Phase sequencing
  always_comb begin
    phase_next = phase;
    unique case (phase)
      rsct_pkg::DR_IDLE: if (ctrl.start) phase_next = rsct_pkg::DR_MUL;
      rsct_pkg::DR_MUL:  if (mul_cnt == '0) phase_next = rsct_pkg::DR_DIV;
      rsct_pkg::DR_DIV:  if (div_cnt == '0) phase_next = rsct_pkg::DR_DONE;
      rsct_pkg::DR_DONE: phase_next = rsct_pkg::DR_IDLE;
      default:           phase_next = rsct_pkg::DR_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done      = (phase == rsct_pkg::DR_DONE);
    remainder = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rsct_pkg::DR_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      gen_x <= seed;
    end
    case (phase)
      rsct_pkg::DR_IDLE: begin
        if (ctrl.start) begin
          acc     <= '0;
          mul_cnt <= 6'(rsct_pkg::MUL_W - 1);
          div_r   <= divisor;
        end
      end
      rsct_pkg::DR_MUL: begin
        acc     <= acc_sum;
        mul_cnt <= mul_cnt - 6'd1;
        if (mul_cnt == '0) begin
          gen_x   <= step_out;
          quot    <= step_out[rsct_pkg::SEED_W-1:rsct_pkg::SEED_W-rsct_pkg::DRAW_W];
          rem     <= '0;
          div_cnt <= 5'(rsct_pkg::DRAW_W - 1);
        end
      end
      rsct_pkg::DR_DIV: begin
        quot    <= {quot[rsct_pkg::DRAW_W-2:0], 1'b0};
        div_cnt <= div_cnt - 5'd1;
        if (!rem_sub[CNT_W]) begin
          rem <= rem_sub[CNT_W-1:0];
        end else begin
          rem <= rem_sh[CNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/random_single_cycle_successor_table.sv
// Top level of the random single-cycle successor table.
`timescale 1ns / 1ps

// Commands arrive on the in_ channel (command, slot_index) and each produces
// exactly one result on the out_ channel (next_slot, status). A transfer
// happens on a rising edge with valid high and stall low. Configuration
// (entry_count, rng_seed) is written through cfg_valid/cfg_ready, which is
// always ready; write it only while the block is idle.
// A generate fills a work list with 1..n-1, shuffles it with one bit-serial
// generator step and one bit-serial remainder per position, then walks the
// list to write the successor table.
// A read's result comes from one registered read of the successor store.
// One command is in work at a time; in_stall is high while it is. A finished
// result waits in the output register while the next command is taken.
// If the receiver stalls, the result holds and the next one waits behind it.
// Reset restores the register defaults and marks the table as not built;
// the table stores themselves are not cleared.
module random_single_cycle_successor_table #(
  parameter int SLOT_DEPTH = rsct_pkg::SLOT_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [rsct_pkg::SLOT_W-1:0]   slot_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsct_pkg::SLOT_W-1:0]   next_slot,
  output logic                          status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [rsct_pkg::SEED_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(SLOT_DEPTH);
  localparam int CNT_W = $clog2(SLOT_DEPTH + 1);
  localparam int SW    = rsct_pkg::SLOT_W;

  rsct_pkg::top_state_t state, state_next;

  logic [rsct_pkg::COUNT_W-1:0] entry_count;
  logic [rsct_pkg::SEED_W-1:0]  rng_seed;
  logic                         cmd_r;
  logic [SW-1:0]                slot_r;
  logic [CNT_W-1:0]             n_r;
  logic [CNT_W-1:0]             n_eff;
  logic [CNT_W-1:0]             i_r;
  logic [CNT_W-1:0]             pick;
  logic [CNT_W-1:0]             remaining;
  logic [IDX_W-1:0]             cur;
  logic [IDX_W-1:0]             tmp_i;
  logic [CNT_W-1:0]             built_count;
  logic                         table_valid;
  logic                         last_pos;
  logic                         out_free;

  // Order store
  logic [IDX_W-1:0] order_mem [SLOT_DEPTH];
  logic [IDX_W-1:0] order_addr;
  logic [IDX_W-1:0] order_wdata;
  logic [IDX_W-1:0] order_rdata;
  logic             order_we;

  // Successor store
  logic [SW-1:0]    succ_mem [SLOT_DEPTH];
  logic [IDX_W-1:0] succ_waddr;
  logic [IDX_W-1:0] succ_raddr;
  logic [SW-1:0]    succ_wdata;
  logic [SW-1:0]    succ_rdata;
  logic             succ_we;

  // Width-neutral views for crossing between slot and index widths
  logic [IDX_W+SW-1:0]  slot_ext;
  logic [IDX_W+SW-1:0]  order_ext;
  logic [CNT_W+SW-1:0]  slot_cmp;
  logic [CNT_W+SW-1:0]  built_cmp;
  logic                 in_range;

  rsct_pkg::draw_ctrl_t      draw_ctrl;
  logic                      draw_done;
  logic [CNT_W-1:0]          draw_rem;

  logic [31:0] ec32;

  // Clamp the configured count into two .. SLOT_DEPTH.
  always_comb begin
    ec32 = 32'(entry_count);
    if (ec32 < 32'd2) begin
      n_eff = CNT_W'(2);
    end else if (ec32 > 32'(SLOT_DEPTH)) begin
      n_eff = CNT_W'(SLOT_DEPTH);
    end else begin
      n_eff = ec32[CNT_W-1:0];
    end
  end

  assign remaining = n_r - CNT_W'(1) - i_r;
  assign pick      = i_r + draw_rem;
  assign last_pos  = (i_r == n_r - CNT_W'(2));
  assign out_free  = !out_valid || !out_stall;

  assign slot_ext  = {{IDX_W{1'b0}}, slot_r};
  assign order_ext = {{SW{1'b0}}, order_rdata};
  assign slot_cmp  = {{CNT_W{1'b0}}, slot_r};
  assign built_cmp = {{SW{1'b0}}, built_count};
  assign in_range  = slot_cmp < built_cmp;

  assign in_stall  = (state != rsct_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  rsct_draw #(
    .SLOT_DEPTH (SLOT_DEPTH)
  ) u_draw (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (draw_ctrl),
    .seed      (rng_seed),
    .divisor   (remaining),
    .done      (draw_done),
    .remainder (draw_rem)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rsct_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (command == rsct_pkg::CMD_GENERATE) ? rsct_pkg::ST_FILL
                                                           : rsct_pkg::ST_READ;
        end
      end
      rsct_pkg::ST_FILL:      if (last_pos) state_next = rsct_pkg::ST_DRAW;
      rsct_pkg::ST_DRAW:      state_next = rsct_pkg::ST_DRAW_WAIT;
      rsct_pkg::ST_DRAW_WAIT: if (draw_done) state_next = rsct_pkg::ST_SWAP_RD_I;
      rsct_pkg::ST_SWAP_RD_I: state_next = rsct_pkg::ST_SWAP_RD_P;
      rsct_pkg::ST_SWAP_RD_P: state_next = rsct_pkg::ST_SWAP_WR_I;
      rsct_pkg::ST_SWAP_WR_I: state_next = rsct_pkg::ST_SWAP_WR_P;
      rsct_pkg::ST_SWAP_WR_P: begin
        state_next = last_pos ? rsct_pkg::ST_TAIL : rsct_pkg::ST_DRAW;
      end
      rsct_pkg::ST_TAIL:      state_next = rsct_pkg::ST_WALK_RD;
      rsct_pkg::ST_WALK_RD:   state_next = rsct_pkg::ST_WALK_WR;
      rsct_pkg::ST_WALK_WR: begin
        if (i_r == n_r - CNT_W'(1)) state_next = rsct_pkg::ST_RESULT;
        else state_next = rsct_pkg::ST_WALK_RD;
      end
      rsct_pkg::ST_READ:      state_next = rsct_pkg::ST_RESULT;
      rsct_pkg::ST_RESULT:    if (out_free) state_next = rsct_pkg::ST_IDLE;
      default:                state_next = rsct_pkg::ST_IDLE;
    endcase
  end

  // Store and draw unit controls
  always_comb begin
    order_we    = 1'b0;
    order_addr  = i_r[IDX_W-1:0];
    order_wdata = order_rdata;
    succ_we     = 1'b0;
    succ_wdata  = order_ext[SW-1:0];
    draw_ctrl   = '0;
    unique case (state)
      rsct_pkg::ST_FILL: begin
        order_we    = 1'b1;
        order_wdata = IDX_W'(i_r + CNT_W'(1));
        draw_ctrl.load = 1'b1;
      end
      rsct_pkg::ST_DRAW:      draw_ctrl.start = 1'b1;
      rsct_pkg::ST_SWAP_RD_P: order_addr = pick[IDX_W-1:0];
      rsct_pkg::ST_SWAP_WR_I: order_we = 1'b1;
      rsct_pkg::ST_SWAP_WR_P: begin
        order_we    = 1'b1;
        order_addr  = pick[IDX_W-1:0];
        order_wdata = tmp_i;
      end
      rsct_pkg::ST_TAIL: begin
        order_we    = 1'b1;
        order_addr  = IDX_W'(n_r - CNT_W'(1));
        order_wdata = '0;
      end
      rsct_pkg::ST_WALK_WR:   succ_we = 1'b1;
      default: begin
      end
    endcase
  end

  assign succ_waddr = cur;
  assign succ_raddr = slot_ext[IDX_W-1:0];

  // Order store: one port, registered read.
  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_addr] <= order_wdata;
    end
    order_rdata <= order_mem[order_addr];
  end

  // Successor store: write during the walk, read for commands.
  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ_mem[succ_waddr] <= succ_wdata;
    end
    succ_rdata <= succ_mem[succ_raddr];
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rsct_pkg::ST_IDLE;
      entry_count <= rsct_pkg::ENTRY_COUNT_RESET;
      rng_seed    <= rsct_pkg::SEED_RESET;
      table_valid <= 1'b0;
      built_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          rsct_pkg::CFG_ENTRY_COUNT: entry_count <= cfg_data[rsct_pkg::COUNT_W-1:0];
          rsct_pkg::CFG_RNG_SEED:    rng_seed    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == rsct_pkg::ST_WALK_WR && i_r == n_r - CNT_W'(1)) begin
        table_valid <= 1'b1;
        built_count <= n_r;
      end
      if (state == rsct_pkg::ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the result register
  always_ff @(posedge clk) begin
    case (state)
      rsct_pkg::ST_IDLE: begin
        cmd_r  <= command;
        slot_r <= slot_index;
        n_r    <= n_eff;
        i_r    <= '0;
      end
      rsct_pkg::ST_FILL: begin
        i_r <= last_pos ? '0 : i_r + CNT_W'(1);
      end
      rsct_pkg::ST_SWAP_RD_P: tmp_i <= order_rdata;
      rsct_pkg::ST_SWAP_WR_P: begin
        if (!last_pos) i_r <= i_r + CNT_W'(1);
      end
      rsct_pkg::ST_TAIL: begin
        i_r <= '0;
        cur <= '0;
      end
      rsct_pkg::ST_WALK_WR: begin
        cur <= order_rdata;
        i_r <= i_r + CNT_W'(1);
      end
      rsct_pkg::ST_RESULT: begin
        if (out_free) begin
          if (cmd_r == rsct_pkg::CMD_GENERATE) begin
            next_slot <= '0;
            status    <= 1'b0;
          end else if (!table_valid) begin
            next_slot <= '0;
            status    <= 1'b1;
          end else begin
            next_slot <= in_range ? succ_rdata : '0;
            status    <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // A flagged result never carries a slot.
  a_status_zero_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> next_slot == '0)
    else $error("status flagged with nonzero next_slot");

  // The draw remainder is always below the count still to shuffle.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    draw_done |-> draw_rem < remaining)
    else $error("draw remainder not below remaining count");

  // A finished generate leaves a valid table behind.
  a_gen_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == rsct_pkg::ST_RESULT && cmd_r == rsct_pkg::CMD_GENERATE |-> table_valid)
    else $error("generate finished without a valid table");

  // The successor store is written only during the walk.
  a_succ_write_walk: assert property (@(posedge clk) disable iff (rst)
    succ_we |-> state == rsct_pkg::ST_WALK_WR && cmd_r == rsct_pkg::CMD_GENERATE)
    else $error("successor store written outside the walk");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the random single-cycle successor table.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    bit [rsct_pkg::SLOT_W-1:0] next_slot;
    bit                        status;
  } successor_reply_t;

  // Predicts the block and checks its replies in order.
  class successor_scoreboard;
    bit [rsct_pkg::COUNT_W-1:0] count_reg = rsct_pkg::ENTRY_COUNT_RESET;
    bit [rsct_pkg::SEED_W-1:0]  seed_reg  = rsct_pkg::SEED_RESET;
    bit [rsct_pkg::SLOT_W-1:0]  succ_store [rsct_pkg::SLOT_DEPTH_DEFAULT];
    int               walk_list  [rsct_pkg::SLOT_DEPTH_DEFAULT];
    bit               built      = 0;
    int               built_slots = 0;
    int               errors     = 0;
    successor_reply_t pending[$];

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Shuffle 1..n-1 with the 48-bit generator and link the cycle from slot 0.
    function void build_cycle();
      int               n;
      int               i;
      int               pick;
      int               tmp;
      int               cur;
      longint unsigned  lcg;
      longint unsigned  draw;
      n = int'(count_reg);
      if (n < 2) n = 2;
      if (n > rsct_pkg::SLOT_DEPTH_DEFAULT) n = rsct_pkg::SLOT_DEPTH_DEFAULT;
      for (i = 0; i + 1 < n; i++) walk_list[i] = i + 1;
      lcg = 64'(seed_reg);
      for (i = 0; i + 1 < n; i++) begin
        lcg = (lcg * 64'h5_DEEC_E66D + 64'hB) & 64'hFFFF_FFFF_FFFF;
        draw = lcg >> 17;
        pick = i + int'(draw % longint'(n - 1 - i));
        tmp = walk_list[i];
        walk_list[i] = walk_list[pick];
        walk_list[pick] = tmp;
      end
      walk_list[n - 1] = 0;
      cur = 0;
      for (i = 0; i < n; i++) begin
        succ_store[cur] = walk_list[i][rsct_pkg::SLOT_W-1:0];
        cur = walk_list[i];
      end
      built_slots = n;
      built = 1;
    endfunction

    // An accepted command: work out its reply.
    function void note_command(bit cmd, bit [rsct_pkg::SLOT_W-1:0] idx);
      successor_reply_t r;
      r.next_slot = '0;
      r.status = 0;
      if (cmd == rsct_pkg::CMD_GENERATE) begin
        build_cycle();
      end else if (!built) begin
        r.status = 1;
      end else if (idx < built_slots) begin
        r.next_slot = succ_store[idx];
      end
      pending.push_back(r);
    endfunction

    task check_reply(bit [rsct_pkg::SLOT_W-1:0] nxt, bit st);
      successor_reply_t r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected reply next_slot=%0d status=%0d", nxt, st));
      end else begin
        r = pending.pop_front();
        if (nxt !== r.next_slot)
          report($sformatf("next_slot %0d, predicted %0d", nxt, r.next_slot));
        if (st !== r.status)
          report($sformatf("status %0d, predicted %0d", st, r.status));
      end
    endtask
  endclass

  logic                          clk = 0;
  logic                          rst = 1;
  logic                          in_valid = 0;
  logic                          in_stall;
  logic                          command = 0;
  logic [rsct_pkg::SLOT_W-1:0]   slot_index = '0;
  logic                          out_valid;
  logic                          out_stall = 0;
  logic [rsct_pkg::SLOT_W-1:0]   next_slot;
  logic                          status;
  logic                          cfg_valid = 0;
  logic                          cfg_ready;
  logic                          cfg_index = 0;
  logic [rsct_pkg::SEED_W-1:0]   cfg_data = '0;

  successor_scoreboard sb = new();
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int quiet_cycles = 0;

  random_single_cycle_successor_table u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .slot_index(slot_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_slot(next_slot), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Receiver back-pressure.
  always @(posedge clk) out_stall <= ($urandom_range(99) < out_idle_pct);

  // Observe transfers on both channels and keep the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_reply(next_slot, status);
      if (in_valid && !in_stall) sb.note_command(command, slot_index);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("random_single_cycle_successor_table verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task send_command(bit cmd, bit [rsct_pkg::SLOT_W-1:0] idx);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    slot_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  // Let every reply drain before touching the registers.
  task wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(bit idx, bit [rsct_pkg::SEED_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == rsct_pkg::CFG_ENTRY_COUNT) sb.count_reg = data[rsct_pkg::COUNT_W-1:0];
    else sb.seed_reg = data;
  endtask

  task random_phase(int items);
    int k;
    for (k = 0; k < items; k++) begin
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(99) < 60) begin
          wait_idle();
          if ($urandom_range(9) == 0)
            write_reg(rsct_pkg::CFG_ENTRY_COUNT, 48'($urandom_range(2047)));
          else
            write_reg(rsct_pkg::CFG_ENTRY_COUNT, 48'($urandom_range(40, 2)));
          write_reg(rsct_pkg::CFG_RNG_SEED, 48'({$urandom, $urandom}));
        end
        send_command(rsct_pkg::CMD_GENERATE, 10'($urandom));
      end else begin
        // Mostly slots within the cycle, some beyond it.
        if ($urandom_range(99) < 80 && sb.built_slots > 0)
          send_command(rsct_pkg::CMD_READ, 10'($urandom_range(sb.built_slots - 1)));
        else
          send_command(rsct_pkg::CMD_READ, 10'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reads before any table, the default full table, extremes.
    send_command(rsct_pkg::CMD_READ, 10'd0);
    send_command(rsct_pkg::CMD_READ, 10'h3FF);
    send_command(rsct_pkg::CMD_GENERATE, 10'h3FF);
    send_command(rsct_pkg::CMD_READ, 10'd0);
    send_command(rsct_pkg::CMD_READ, 10'h3FF);
    send_command(rsct_pkg::CMD_READ, 10'h2AA);
    send_command(rsct_pkg::CMD_READ, 10'h155);
    wait_idle();
    write_reg(rsct_pkg::CFG_ENTRY_COUNT, 48'd2);
    write_reg(rsct_pkg::CFG_RNG_SEED, 48'd0);
    send_command(rsct_pkg::CMD_GENERATE, 10'd0);
    send_command(rsct_pkg::CMD_READ, 10'd0);
    send_command(rsct_pkg::CMD_READ, 10'd1);
    send_command(rsct_pkg::CMD_READ, 10'd2);
    send_command(rsct_pkg::CMD_READ, 10'h3FF);
    wait_idle();
    // Count changed after generate: reads still use the old cycle.
    write_reg(rsct_pkg::CFG_ENTRY_COUNT, 48'd0);
    send_command(rsct_pkg::CMD_READ, 10'd1);
    send_command(rsct_pkg::CMD_GENERATE, 10'd0);
    send_command(rsct_pkg::CMD_READ, 10'd0);
    send_command(rsct_pkg::CMD_READ, 10'd1);
    wait_idle();
    write_reg(rsct_pkg::CFG_ENTRY_COUNT, 48'h7FF);
    write_reg(rsct_pkg::CFG_RNG_SEED, 48'hFFFF_FFFF_FFFF);
    send_command(rsct_pkg::CMD_GENERATE, 10'd0);
    send_command(rsct_pkg::CMD_READ, 10'h3FF);
    send_command(rsct_pkg::CMD_READ, 10'd1000);
    wait_idle();
    write_reg(rsct_pkg::CFG_ENTRY_COUNT, 48'd17);

    // Random phases under different idling patterns.
    in_idle_pct = 13;
    out_idle_pct = 56;
    random_phase(34);
    wait_idle();
    in_idle_pct = 56;
    out_idle_pct = 13;
    random_phase(33);
    wait_idle();
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_phase(33);
    wait_idle();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("random_single_cycle_successor_table verification clean");
    end else begin
      $display("random_single_cycle_successor_table verification failed");
    end
    $finish;
  end
endmodule

// File: random_single_cycle_successor_table.f
rtl/rsct_pkg.sv
rtl/rsct_draw.sv
rtl/random_single_cycle_successor_table.sv
tb/sv/testbench.sv
